### rtl/crfb_pkg.sv
// ----------------------------------------------------------------------------
// crfb_pkg
// Shared types and constants for the clipped rectangle fill and keyed blit
// engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crfb_pkg;

  localparam int unsigned ScreenWidth  = 240;
  localparam int unsigned ScreenHeight = 160;
  localparam int unsigned MaxSide      = 512;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned SideW   = 9;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 16;

  // Screen coordinate plus counter, one bit wider than the counter term.
  localparam int unsigned PosW = SideW + 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X    = 4'd0,
    REG_ORIGIN_Y    = 4'd1,
    REG_RECT_WIDTH  = 4'd2,
    REG_RECT_HEIGHT = 4'd3,
    REG_FILL_COLOR  = 4'd4,
    REG_KEY_COLOR   = 4'd5,
    REG_DRAW_MODE   = 4'd6,
    REG_TO_DISPLAY  = 4'd7
  } crfb_reg_e;

  localparam logic [ModeW-1:0] MODE_FILL  = 2'd0;
  localparam logic [ModeW-1:0] MODE_COPY  = 2'd1;
  localparam logic [ModeW-1:0] MODE_KEYED = 2'd2;

  localparam logic [SideW-1:0] RESET_WIDTH  = 9'd240;
  localparam logic [SideW-1:0] RESET_HEIGHT = 9'd160;

  // One framebuffer write, as it travels from the front to the back.
  typedef struct packed {
    logic              write_enable;
    logic              target_display;
    logic [AddrW-1:0]  pixel_address;
    logic [ColorW-1:0] pixel_color;
    logic              rect_done;
  } crfb_item_t;

  function automatic logic [PosW-1:0] side_len(input logic [SideW-1:0] v);
    side_len = (v == '0) ? PosW'(MaxSide) : {1'b0, v};
  endfunction

  function automatic logic [AddrW-1:0] row_start(input logic [CoordW-1:0] oy);
    row_start = AddrW'({8'd0, oy} * 16'(ScreenWidth));
  endfunction

endpackage

`default_nettype wire

### rtl/crfb_front.sv
// ----------------------------------------------------------------------------
// crfb_front
// Configuration registers, rectangle walk counters and per-pixel
// classification (clip, key, colour select, address).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crfb_front import crfb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDatW-1:0] cfg_data_i,
  input  wire logic               in_fire_i,
  input  wire logic [ColorW-1:0]  source_pixel_i,
  output crfb_item_t              item_o
);

  logic [CoordW-1:0] origin_x_q, origin_x_d;
  logic [CoordW-1:0] origin_y_q, origin_y_d;
  logic [SideW-1:0]  rect_width_q, rect_width_d;
  logic [SideW-1:0]  rect_height_q, rect_height_d;
  logic [ColorW-1:0] fill_color_q, fill_color_d;
  logic [ColorW-1:0] key_color_q, key_color_d;
  logic [ModeW-1:0]  draw_mode_q, draw_mode_d;
  logic              to_display_q, to_display_d;

  logic [SideW-1:0]  col_q, col_d;
  logic [SideW-1:0]  row_q, row_d;
  logic [AddrW-1:0]  row_base_q, row_base_d;

  logic              restart;
  logic [PosW-1:0]   sx, sy, col_inc, row_inc;
  logic              on_screen, keyed, we, last_col, done;
  logic [ColorW-1:0] color;

  always_comb begin
    origin_x_d    = origin_x_q;
    origin_y_d    = origin_y_q;
    rect_width_d  = rect_width_q;
    rect_height_d = rect_height_q;
    fill_color_d  = fill_color_q;
    key_color_d   = key_color_q;
    draw_mode_d   = draw_mode_q;
    to_display_d  = to_display_q;
    restart       = 1'b0;
    if (cfg_we_i) begin
      restart = 1'b1;
      unique case (cfg_index_i)
        REG_ORIGIN_X:    origin_x_d    = cfg_data_i[CoordW-1:0];
        REG_ORIGIN_Y:    origin_y_d    = cfg_data_i[CoordW-1:0];
        REG_RECT_WIDTH:  rect_width_d  = cfg_data_i[SideW-1:0];
        REG_RECT_HEIGHT: rect_height_d = cfg_data_i[SideW-1:0];
        REG_FILL_COLOR:  fill_color_d  = cfg_data_i;
        REG_KEY_COLOR:   key_color_d   = cfg_data_i;
        REG_DRAW_MODE:   draw_mode_d   = cfg_data_i[ModeW-1:0];
        REG_TO_DISPLAY:  to_display_d  = cfg_data_i[0];
        default:         restart       = 1'b0;
      endcase
    end
  end

  assign sx        = PosW'(origin_x_q) + PosW'(col_q);
  assign sy        = PosW'(origin_y_q) + PosW'(row_q);
  assign col_inc   = PosW'(col_q) + PosW'(1);
  assign row_inc   = PosW'(row_q) + PosW'(1);
  assign on_screen = (sx < PosW'(ScreenWidth)) && (sy < PosW'(ScreenHeight));
  // Mode 3 keys just like mode 2, so only the upper mode bit matters here.
  assign keyed     = draw_mode_q[1] && (source_pixel_i == key_color_q);
  assign we        = on_screen && !keyed;
  assign color     = (draw_mode_q == MODE_FILL) ? fill_color_q : source_pixel_i;
  assign last_col  = col_inc >= side_len(rect_width_q);
  assign done      = last_col && (row_inc >= side_len(rect_height_q));

  always_comb begin
    item_o.write_enable   = we;
    item_o.target_display = to_display_q;
    item_o.pixel_address  = we ? (row_base_q + AddrW'(sx)) : '0;
    item_o.pixel_color    = we ? color : '0;
    item_o.rect_done      = done;
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    if (restart || (in_fire_i && done)) begin
      col_d      = '0;
      row_d      = '0;
      row_base_d = row_start(origin_y_d);
    end else if (in_fire_i && last_col) begin
      col_d      = '0;
      row_d      = row_inc[SideW-1:0];
      row_base_d = row_base_q + AddrW'(ScreenWidth);
    end else if (in_fire_i) begin
      col_d = col_inc[SideW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      rect_width_q  <= RESET_WIDTH;
      rect_height_q <= RESET_HEIGHT;
      fill_color_q  <= '0;
      key_color_q   <= '0;
      draw_mode_q   <= MODE_FILL;
      to_display_q  <= 1'b1;
      col_q         <= '0;
      row_q         <= '0;
      row_base_q    <= '0;
    end else begin
      origin_x_q    <= origin_x_d;
      origin_y_q    <= origin_y_d;
      rect_width_q  <= rect_width_d;
      rect_height_q <= rect_height_d;
      fill_color_q  <= fill_color_d;
      key_color_q   <= key_color_d;
      draw_mode_q   <= draw_mode_d;
      to_display_q  <= to_display_d;
      col_q         <= col_d;
      row_q         <= row_d;
      row_base_q    <= row_base_d;
    end
  end

endmodule

`default_nettype wire

### rtl/crfb_queue.sv
// ----------------------------------------------------------------------------
// crfb_queue
// Two-entry queue of classified writes between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crfb_queue import crfb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire crfb_item_t push_item_i,
  input  wire logic pop_i,
  output crfb_item_t pop_item_o,
  output logic      full_o,
  output logic      empty_o
);

  crfb_item_t  mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/crfb_back.sv
// ----------------------------------------------------------------------------
// crfb_back
// Output register stage: takes writes from the queue and holds each one on
// the result port until its transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crfb_back import crfb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  wire crfb_item_t q_item_i,
  output logic      q_pop_o,
  input  wire logic out_stall_i,
  output logic      out_valid_o,
  output crfb_item_t out_item_o
);

  logic       out_valid_q, out_valid_d;
  crfb_item_t out_item_q;

  assign q_pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_item_q <= q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

### rtl/clipped_rect_fill_and_keyed_blit_core.sv
// Path: each accepted pixel passes the two-entry queue, then the output register.
// Throughput: one pixel per cycle with an unstalled result; the queue and output
// register absorb a stalled result while input transfers go on until the queue fills.
// Reset: asynchronous, active low; restores the register defaults and starts
// the walk at the top-left pixel of the rectangle. No clearing pass.
// ----------------------------------------------------------------------------
// clipped_rect_fill_and_keyed_blit_core
// Rectangle engine: walks a configured rectangle in raster order and emits one
// clipped, optionally colour-keyed framebuffer write per source pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clipped_rect_fill_and_keyed_blit_core import crfb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDatW-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ColorW-1:0]  source_pixel_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    write_enable_o,
  output logic                    target_display_o,
  output logic [AddrW-1:0]        pixel_address_o,
  output logic [ColorW-1:0]       pixel_color_o,
  output logic                    rect_done_o
);

  crfb_item_t front_item, q_item, out_item;
  logic       in_fire, q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign in_fire     = in_valid_i && !q_full;

  crfb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_fire_i      (in_fire),
    .source_pixel_i (source_pixel_i),
    .item_o         (front_item)
  );

  crfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_item_i (front_item),
    .pop_i       (q_pop),
    .pop_item_o  (q_item),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  crfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item)
  );

  assign write_enable_o   = out_item.write_enable;
  assign target_display_o = out_item.target_display;
  assign pixel_address_o  = out_item.pixel_address;
  assign pixel_color_o    = out_item.pixel_color;
  assign rect_done_o      = out_item.rect_done;

endmodule

`default_nettype wire

### rtl/crfb_checker.sv
// ----------------------------------------------------------------------------
// crfb_checker
// Port-level checks for the rectangle engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crfb_checker import crfb_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              write_enable_o,
  input wire logic [AddrW-1:0]  pixel_address_o,
  input wire logic [ColorW-1:0] pixel_color_o
);

  // A stalled result stays offered with the same address and colour.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_address_o)
      && $stable(pixel_color_o) && $stable(write_enable_o))
    else $error("stalled result changed");

  // Suppressed writes carry a zero address and colour.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> pixel_address_o == '0 && pixel_color_o == '0)
    else $error("disabled write with nonzero payload");

  // Enabled writes always land inside the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |->
      pixel_address_o < AddrW'(ScreenWidth * ScreenHeight))
    else $error("write address outside the frame");

  // An input transfer with an idle output yields a result once it has passed
  // the queue and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |-> ##2 out_valid_o)
    else $error("accepted pixel produced no result");

endmodule

bind clipped_rect_fill_and_keyed_blit_core crfb_checker u_crfb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .write_enable_o  (write_enable_o),
  .pixel_address_o (pixel_address_o),
  .pixel_color_o   (pixel_color_o)
);

`default_nettype wire
